FILE: rtl/qbp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qbp_pkg
// Shared types and constants of the quadratic Bezier plotter.
// ----------------------------------------------------------------------------
package qbp_pkg;

   // request payload: restart flag in bit 0, zero filled to one byte
   localparam int REQ_DATA_W  = 8;
   localparam int CSR_INDEX_W = 3;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_START_X   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_START_Y   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_CONTROL_X = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_CONTROL_Y = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_END_X     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_END_Y     = 3'd5;

   // sequencer states
   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_WEIGHT = 5'b00010,
      ST_SUM    = 5'b00100,
      ST_DIV    = 5'b01000,
      ST_EMIT   = 5'b10000
   } state_type;

   // which coordinate the shared datapath works on
   typedef enum logic {
      AXIS_X = 1'b0,
      AXIS_Y = 1'b1
   } axis_type;

endpackage

FILE: rtl/qbp_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qbp_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module qbp_mul #(
   parameter int A_W = 22,
   parameter int B_W = 12
) (
   input  logic                 clock,
   input  logic [A_W-1:0]       op_a,
   input  logic [B_W-1:0]       op_b,
   output logic [A_W+B_W-1:0]   product_ff
);

   localparam int P_W = A_W + B_W;

   logic [P_W-1:0] product_in;

   assign product_in = P_W'(op_a) * P_W'(op_b);

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

endmodule

FILE: rtl/qbp_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qbp_div
// Divide by the constant STEPS squared (a power of two) as a registered shift.
// ----------------------------------------------------------------------------
module qbp_div #(
   parameter int STEPS = 1024,
   parameter int N_W   = 34,
   parameter int Q_W   = 12
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [N_W-1:0]   dividend,
   output logic             done_ff,
   output logic [Q_W-1:0]   quotient_ff
);

   // STEPS squared is 2^(2*log2(STEPS)): drop that many low bits
   localparam int SH = 2 * $clog2(STEPS);

   logic [Q_W-1:0] quotient_in;
   logic           done_in;

   assign quotient_in = Q_W'(dividend >> SH);
   assign done_in     = start;

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
      end
   end

   // hold the quotient until the next start
   always_ff @(posedge clock) begin
      if (start) begin
         quotient_ff <= quotient_in;
      end
   end

endmodule

FILE: rtl/quadratic_bezier_plotter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_bezier_plotter_unit
// Steps a quadratic Bezier curve one point per request item.
// ----------------------------------------------------------------------------
//  channel   dir   handshake            payload
//  req_      in    tvalid/tready        tdata[0] restart
//  rsp_      out   tvalid/tready        tdata {pixel_y, pixel_x}, tuser new_pixel,
//                                       tlast final_step
//  csr_      in    we (no wait)         index, wdata (one coordinate)
//
//  An item occupies the sequencer from its accepting edge: the weight products
//  on the shared multiplier, then per axis the three weighted products from
//  the registered multiplier and the registered shift by STEPS^2, then the emit
//  step. The next item is accepted only after the sequencer is back in idle.
//  req_tready is high only while the sequencer idles; the result register
//  holds a finished item while the next one is already being computed, and a
//  result that still waits holds the next item in its emit step.
//  Reset is synchronous and clears step count, last pixel, result valid and the configuration registers.
// ----------------------------------------------------------------------------
module quadratic_bezier_plotter_unit #(
   parameter int STEPS      = 1024,    // a power of two
   parameter int COORD_BITS = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   // request: bit 0 restart
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [qbp_pkg::REQ_DATA_W-1:0]      req_tdata,
   // result: pixel_x from bit 0, then pixel_y, zero filled to bytes
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [((2*COORD_BITS+7)/8)*8-1:0]   rsp_tdata,
   // result flag: new_pixel
   output logic                                rsp_tuser,
   output logic                                rsp_tlast,
   // configuration writes
   input  logic                                csr_we,
   input  logic [qbp_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [COORD_BITS-1:0]               csr_wdata
);

   localparam int CB   = COORD_BITS;
   localparam int KW   = $clog2(STEPS);         // step index k
   localparam int RW   = $clog2(STEPS + 1);     // STEPS - k, up to STEPS
   localparam int WW   = 2 * RW;                // squared weights
   localparam int BW   = (RW > CB) ? RW : CB;   // second multiplier operand
   localparam int PW   = WW + BW;               // product
   localparam int AW   = WW + CB;               // weighted sum
   localparam int OW   = ((2 * CB + 7) / 8) * 8;

   // ---------------------------------------------------------------- registers
   logic [CB-1:0] start_x_ff, start_y_ff, control_x_ff, control_y_ff;
   logic [CB-1:0] end_x_ff, end_y_ff;

   qbp_pkg::state_type state_ff, state_in;
   qbp_pkg::axis_type  axis_ff, axis_in;
   logic [1:0]         cnt_ff, cnt_in;

   logic [KW-1:0] step_ff, step_in;     // next step of the curve
   logic [KW-1:0] k_ff, k_in;           // step of the item in work
   logic          have_prev_ff, have_prev_in;
   logic [CB-1:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;

   logic [WW-1:0] w0_ff, w0_in, w1_ff, w1_in, w2_ff, w2_in;
   logic [AW-1:0] acc_ff, acc_in;
   logic [CB-1:0] px_ff, px_in, py_ff, py_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [OW-1:0] rsp_data_ff, rsp_data_in;
   logic          rsp_user_ff, rsp_user_in, rsp_last_ff, rsp_last_in;

   // ------------------------------------------------------------ shared units
   logic [WW-1:0] mul_a;
   logic [BW-1:0] mul_b;
   logic [PW-1:0] product;
   logic          div_start;
   logic [AW-1:0] div_dividend;
   logic          div_done;
   logic [CB-1:0] quotient;

   qbp_mul #(.A_W(WW), .B_W(BW)) u_mul (
      .clock      (clock),
      .op_a       (mul_a),
      .op_b       (mul_b),
      .product_ff (product)
   );

   qbp_div #(.STEPS(STEPS), .N_W(AW), .Q_W(CB)) u_div (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .dividend    (div_dividend),
      .done_ff     (div_done),
      .quotient_ff (quotient)
   );

   // ------------------------------------------------------------ helpers
   logic [RW-1:0] r_val;
   logic [CB-1:0] p0_sel, p1_sel, p2_sel;
   logic          accept, last, fresh, out_free;
   logic [KW-1:0] k_start;

   assign r_val   = RW'(STEPS) - RW'(k_ff);
   assign p0_sel  = (axis_ff == qbp_pkg::AXIS_X) ? start_x_ff   : start_y_ff;
   assign p1_sel  = (axis_ff == qbp_pkg::AXIS_X) ? control_x_ff : control_y_ff;
   assign p2_sel  = (axis_ff == qbp_pkg::AXIS_X) ? end_x_ff     : end_y_ff;
   assign accept  = req_tvalid && req_tready;
   assign k_start = req_tdata[0] ? '0 : step_ff;
   assign last    = (k_ff == KW'(STEPS - 1));
   assign fresh   = !have_prev_ff || (px_ff != prev_x_ff) || (py_ff != prev_y_ff);
   assign out_free = !rsp_valid_ff || rsp_tready;

   assign req_tready = (state_ff == qbp_pkg::ST_IDLE);

   // weighted sum is complete once the third product lands
   assign div_start    = (state_ff == qbp_pkg::ST_SUM) && (cnt_ff == 2'd3);
   assign div_dividend = acc_ff + AW'(product);

   // multiplier operand schedule
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         qbp_pkg::ST_WEIGHT: begin
            case (cnt_ff)
               2'd0: begin mul_a = WW'(r_val); mul_b = BW'(r_val); end
               2'd1: begin mul_a = WW'(r_val); mul_b = BW'(k_ff);  end
               2'd2: begin mul_a = WW'(k_ff);  mul_b = BW'(k_ff);  end
               default: ;
            endcase
         end
         qbp_pkg::ST_SUM: begin
            case (cnt_ff)
               2'd0: begin mul_a = w0_ff; mul_b = BW'(p0_sel); end
               2'd1: begin mul_a = w1_ff; mul_b = BW'(p1_sel); end
               2'd2: begin mul_a = w2_ff; mul_b = BW'(p2_sel); end
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      axis_in      = axis_ff;
      cnt_in       = cnt_ff;
      step_in      = step_ff;
      k_in         = k_ff;
      have_prev_in = have_prev_ff;
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      w0_in        = w0_ff;
      w1_in        = w1_ff;
      w2_in        = w2_ff;
      acc_in       = acc_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;

      case (state_ff)
         qbp_pkg::ST_IDLE: begin
            if (accept) begin
               // restart drops the last pixel before this point is formed
               k_in = k_start;
               if (req_tdata[0]) begin
                  have_prev_in = 1'b0;
               end
               step_in  = (k_start == KW'(STEPS - 1)) ? '0 : k_start + KW'(1);
               cnt_in   = 2'd0;
               axis_in  = qbp_pkg::AXIS_X;
               state_in = qbp_pkg::ST_WEIGHT;
            end
         end
         qbp_pkg::ST_WEIGHT: begin
            cnt_in = cnt_ff + 2'd1;
            case (cnt_ff)
               2'd1: w0_in = WW'(product);
               2'd2: w1_in = WW'(product << 1);
               2'd3: begin
                  w2_in    = WW'(product);
                  cnt_in   = 2'd0;
                  state_in = qbp_pkg::ST_SUM;
               end
               default: ;
            endcase
         end
         qbp_pkg::ST_SUM: begin
            cnt_in = cnt_ff + 2'd1;
            case (cnt_ff)
               2'd1: acc_in = AW'(product);
               2'd2: acc_in = acc_ff + AW'(product);
               2'd3: begin
                  cnt_in   = 2'd0;
                  state_in = qbp_pkg::ST_DIV;
               end
               default: ;
            endcase
         end
         qbp_pkg::ST_DIV: begin
            if (div_done) begin
               if (axis_ff == qbp_pkg::AXIS_X) begin
                  px_in    = quotient;
                  axis_in  = qbp_pkg::AXIS_Y;
                  state_in = qbp_pkg::ST_SUM;
               end else begin
                  py_in    = quotient;
                  state_in = qbp_pkg::ST_EMIT;
               end
            end
         end
         qbp_pkg::ST_EMIT: begin
            // hold until the result register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = OW'({py_ff, px_ff});
               rsp_user_in  = fresh;
               rsp_last_in  = last;
               if (fresh) begin
                  prev_x_in    = px_ff;
                  prev_y_in    = py_ff;
                  have_prev_in = 1'b1;
               end
               // the curve starts over after its final step
               if (last) begin
                  have_prev_in = 1'b0;
               end
               state_in = qbp_pkg::ST_IDLE;
            end
         end
         default: state_in = qbp_pkg::ST_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= qbp_pkg::ST_IDLE;
         axis_ff      <= qbp_pkg::AXIS_X;
         cnt_ff       <= '0;
         step_ff      <= '0;
         have_prev_ff <= 1'b0;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         cnt_ff       <= cnt_in;
         step_ff      <= step_in;
         have_prev_ff <= have_prev_in;
         prev_x_ff    <= prev_x_in;
         prev_y_ff    <= prev_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      k_ff        <= k_in;
      w0_ff       <= w0_in;
      w1_ff       <= w1_in;
      w2_ff       <= w2_in;
      acc_ff      <= acc_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
   end

   // configuration registers; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         start_x_ff   <= '0;
         start_y_ff   <= '0;
         control_x_ff <= '0;
         control_y_ff <= '0;
         end_x_ff     <= '0;
         end_y_ff     <= '0;
      end else if (csr_we) begin
         case (csr_index)
            qbp_pkg::REG_START_X:   start_x_ff   <= csr_wdata;
            qbp_pkg::REG_START_Y:   start_y_ff   <= csr_wdata;
            qbp_pkg::REG_CONTROL_X: control_x_ff <= csr_wdata;
            qbp_pkg::REG_CONTROL_Y: control_y_ff <= csr_wdata;
            qbp_pkg::REG_END_X:     end_x_ff     <= csr_wdata;
            qbp_pkg::REG_END_Y:     end_y_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

FILE: tb/tb_quadratic_bezier_plotter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quadratic_bezier_plotter_unit
// Self-checking bench for the quadratic Bezier plotter: ticks go in on the
// req_ stream, curve points come back on rsp_ and are checked field by field
// against a bit-exact integer predictor of the curve stepper. Control points
// are reloaded between phases while the block is drained.
// ----------------------------------------------------------------------------
module tb_quadratic_bezier_plotter_unit;

   localparam int STEPS      = 1024;
   localparam int COORD_BITS = 12;
   localparam int RSP_DATA_W = ((2*COORD_BITS+7)/8)*8;
   // settle time for one item without stalls, plus margin
   localparam int SETTLE_CYCLES = 16 + 8;
   localparam int WATCHDOG_LIMIT = 4000;

   // indexes past the last register; writes there must be ignored
   localparam logic [qbp_pkg::CSR_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [qbp_pkg::CSR_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic                  fresh;
      logic                  last;
   } curve_pixel_type;

   // -------------------------------------------------------------------------
   // Curve predictor and store of pixels still owed by the block
   // -------------------------------------------------------------------------
   class bezier_checker_type;
      logic [COORD_BITS-1:0] coord [6];
      int unsigned           step;
      logic [COORD_BITS-1:0] last_x, last_y;
      bit                    have_last;
      curve_pixel_type       owed_pixels [$];
      int                    errors, ticks, pixels, finals, fresh_count;

      function new();
         foreach (coord[i]) coord[i] = '0;
         step = 0; last_x = '0; last_y = '0; have_last = 0;
         errors = 0; ticks = 0; pixels = 0; finals = 0; fresh_count = 0;
      endfunction

      function void load_register(logic [qbp_pkg::CSR_INDEX_W-1:0] idx,
                                  logic [COORD_BITS-1:0] value);
         if (idx <= qbp_pkg::REG_END_Y) coord[idx] = value;
      endfunction

      // floor(((S-k)^2*p0 + 2k(S-k)*p1 + k^2*p2) / S^2)
      function logic [COORD_BITS-1:0] axis_value(logic [COORD_BITS-1:0] p0,
                                                 logic [COORD_BITS-1:0] p1,
                                                 logic [COORD_BITS-1:0] p2,
                                                 int unsigned k);
         bit [63:0] kk, rr, acc;
         kk  = 64'(k);
         rr  = 64'(STEPS) - kk;
         acc = rr*rr*64'(p0) + 64'd2*kk*rr*64'(p1) + kk*kk*64'(p2);
         return COORD_BITS'(acc / (64'(STEPS) * 64'(STEPS)));
      endfunction

      function curve_pixel_type next_curve_point(bit restart);
         curve_pixel_type p;
         if (restart) begin
            step = 0;
            have_last = 0;
         end
         if (step >= STEPS) step = 0;
         p.x = axis_value(coord[qbp_pkg::REG_START_X], coord[qbp_pkg::REG_CONTROL_X],
                          coord[qbp_pkg::REG_END_X], step);
         p.y = axis_value(coord[qbp_pkg::REG_START_Y], coord[qbp_pkg::REG_CONTROL_Y],
                          coord[qbp_pkg::REG_END_Y], step);
         p.fresh = !have_last || p.x != last_x || p.y != last_y;
         if (p.fresh) begin
            last_x = p.x;
            last_y = p.y;
            have_last = 1;
         end
         p.last = (step == STEPS - 1);
         if (p.last) begin
            step = 0;
            have_last = 0;
         end else begin
            step = step + 1;
         end
         return p;
      endfunction

      task report_mismatch(string what, longint unsigned want, longint unsigned got);
         errors++;
         $display("%0t mismatch on %s: expected %0d, got %0d", $time, what, want, got);
      endtask

      function void note_tick(bit restart);
         owed_pixels.push_back(next_curve_point(restart));
         ticks++;
      endfunction

      task check_pixel(logic [RSP_DATA_W-1:0] data, logic user, logic tlast);
         curve_pixel_type want;
         pixels++;
         if (owed_pixels.size() == 0) begin
            report_mismatch("unexpected pixel count", 64'd0, 64'(pixels));
         end else begin
            want = owed_pixels.pop_front();
            if (data[COORD_BITS-1:0] !== want.x)
               report_mismatch("pixel_x", 64'(want.x), 64'(data[COORD_BITS-1:0]));
            if (data[2*COORD_BITS-1:COORD_BITS] !== want.y)
               report_mismatch("pixel_y", 64'(want.y),
                               64'(data[2*COORD_BITS-1:COORD_BITS]));
            if (user !== want.fresh)
               report_mismatch("new_pixel", 64'(want.fresh), 64'(user));
            if (tlast !== want.last)
               report_mismatch("final_step", 64'(want.last), 64'(tlast));
            if (want.fresh) fresh_count++;
            if (want.last) finals++;
         end
      endtask

      task close_out();
         if (owed_pixels.size() != 0)
            report_mismatch("pixels never delivered", 64'd0, 64'(owed_pixels.size()));
      endtask
   endclass

   // -------------------------------------------------------------------------
   // Block under test
   // -------------------------------------------------------------------------
   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [qbp_pkg::REQ_DATA_W-1:0]    req_tdata = '0;   // [0] restart, rest zero fill
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b1;
   logic [RSP_DATA_W-1:0]             rsp_tdata;        // [11:0] pixel_x, [23:12] pixel_y
   logic                              rsp_tuser;        // [0] new_pixel
   logic                              rsp_tlast;
   logic                              csr_we = 1'b0;
   logic [qbp_pkg::CSR_INDEX_W-1:0]   csr_index = '0;
   logic [COORD_BITS-1:0]             csr_wdata = '0;

   quadratic_bezier_plotter_unit #(
      .STEPS(STEPS),
      .COORD_BITS(COORD_BITS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   bezier_checker_type checker_h = new();
   bit                 quiet = 0;     // set for the tail of the run: no idling anywhere
   int                 idle_cycles = 0;

   // -------------------------------------------------------------------------
   // Monitor: sample both handshakes at the rising edge
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) checker_h.note_tick(req_tdata[0]);
         if (rsp_tvalid && rsp_tready) checker_h.check_pixel(rsp_tdata, rsp_tuser, rsp_tlast);
      end
   end

   // Watchdog: count cycles in which no item moves on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      wait (idle_cycles >= WATCHDOG_LIMIT);
      $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("[quadratic_bezier_plotter_unit] ERROR");
      $finish;
   end

   // Receiver: stall in random bursts, never in the quiet tail
   int rsp_stall_left = 0;
   always @(negedge clock) begin
      if (quiet) begin
         rsp_tready <= 1'b1;
         rsp_stall_left <= 0;
      end else if (rsp_stall_left > 0) begin
         rsp_tready <= 1'b0;
         rsp_stall_left <= rsp_stall_left - 1;
      end else if ($urandom_range(0, 4) == 0) begin
         rsp_tready <= 1'b0;
         rsp_stall_left <= $urandom_range(0, 5);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // -------------------------------------------------------------------------
   // Drivers. Every task starts and ends right after a falling edge.
   // -------------------------------------------------------------------------

   // Offer one tick; optionally hold off a random burst before it.
   task send_tick(bit restart);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(qbp_pkg::REQ_DATA_W-1){1'b0}}, restart};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // Drop valid and hold until every owed pixel is back and the block settled.
   task drain();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (checker_h.owed_pixels.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task write_reg(logic [qbp_pkg::CSR_INDEX_W-1:0] idx, logic [COORD_BITS-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      checker_h.load_register(idx, value);
      @(negedge clock);
   endtask

   task load_curve(logic [COORD_BITS-1:0] x0, logic [COORD_BITS-1:0] y0,
                   logic [COORD_BITS-1:0] x1, logic [COORD_BITS-1:0] y1,
                   logic [COORD_BITS-1:0] x2, logic [COORD_BITS-1:0] y2);
      write_reg(qbp_pkg::REG_START_X, x0);
      write_reg(qbp_pkg::REG_START_Y, y0);
      write_reg(qbp_pkg::REG_CONTROL_X, x1);
      write_reg(qbp_pkg::REG_CONTROL_Y, y1);
      write_reg(qbp_pkg::REG_END_X, x2);
      write_reg(qbp_pkg::REG_END_Y, y2);
   endtask

   task load_random_curve();
      load_curve(COORD_BITS'($urandom_range(0, 4095)), COORD_BITS'($urandom_range(0, 4095)),
                 COORD_BITS'($urandom_range(0, 4095)), COORD_BITS'($urandom_range(0, 4095)),
                 COORD_BITS'($urandom_range(0, 4095)), COORD_BITS'($urandom_range(0, 4095)));
   endtask

   // Points clustered within a few pixels: many repeated pixels per curve.
   task load_tight_curve();
      int bx, by;
      bx = $urandom_range(0, 4080);
      by = $urandom_range(0, 4080);
      load_curve(COORD_BITS'(bx + $urandom_range(0, 15)),
                 COORD_BITS'(by + $urandom_range(0, 15)),
                 COORD_BITS'(bx + $urandom_range(0, 15)),
                 COORD_BITS'(by + $urandom_range(0, 15)),
                 COORD_BITS'(bx + $urandom_range(0, 15)),
                 COORD_BITS'(by + $urandom_range(0, 15)));
   endtask

   // Run n ticks with a restart roughly once every restart_odds items.
   task run_ticks(int n, int restart_odds);
      repeat (n) send_tick($urandom_range(1, restart_odds) == 1);
   endtask

   // -------------------------------------------------------------------------
   // Sequence
   // -------------------------------------------------------------------------
   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: first tick after reset uses all-zero points, then extremes.
      send_tick(1'b0);
      send_tick(1'b0);
      drain();
      load_curve(12'd0, 12'd0, 12'd4095, 12'd4095, 12'd4095, 12'd0);
      send_tick(1'b1);
      repeat (5) send_tick(1'b0);
      send_tick(1'b1);      // restart mid-curve
      send_tick(1'b1);      // restart twice in a row
      repeat (3) send_tick(1'b0);
      drain();
      // spare indexes must not disturb any coordinate
      write_reg(REG_SPARE_LO, 12'd4095);
      write_reg(REG_SPARE_HI, 12'd4095);
      repeat (3) send_tick(1'b0);   // curve continues across the writes
      drain();
      load_curve(12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095);
      send_tick(1'b1);
      repeat (3) send_tick(1'b0);   // constant point: only the first is new

      // All-zero curve: pixel never moves.
      drain();
      load_curve(12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0);
      run_ticks(150, 32);

      // Max corner against origin.
      drain();
      load_curve(12'd4095, 12'd0, 12'd0, 12'd4095, 12'd0, 12'd4095);
      run_ticks(100, 32);

      // One full curve and past it: reach the final step and wrap around.
      drain();
      load_random_curve();
      send_tick(1'b1);
      run_ticks(599, 1 << 30);
      drain();              // sender waits for every owed pixel mid-curve
      run_ticks(500, 1 << 30);

      // Clustered points, loaded mid-curve.
      drain();
      load_tight_curve();
      run_ticks(300, 16);

      // Tail without idling on either side.
      drain();
      load_random_curve();
      quiet = 1;
      run_ticks(200, 64);

      drain();
      checker_h.close_out();
      $display("covered %0d ticks and %0d pixels, %0d new, %0d final steps",
               checker_h.ticks, checker_h.pixels, checker_h.fresh_count, checker_h.finals);
      $display("mismatches: %0d", checker_h.errors);
      if (checker_h.errors == 0)
         $display("[quadratic_bezier_plotter_unit] OK");
      else
         $display("[quadratic_bezier_plotter_unit] ERROR");
      $finish;
   end

endmodule

FILE: files.f
rtl/qbp_pkg.sv
rtl/qbp_mul.sv
rtl/qbp_div.sv
rtl/quadratic_bezier_plotter_unit.sv
tb/tb_quadratic_bezier_plotter_unit.sv
